[sv/att_pkg.sv]
// Shared types, constants and character classes of the assembly text tokenizer.
package att_pkg;

  localparam int unsigned MAX_TOKEN_LENGTH = 31;
  localparam int unsigned LEN_W  = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_TOKEN_LENGTH);
  localparam int unsigned APB_ADDR_W = 3;

  typedef logic [7:0]        char_t;
  typedef logic [2:0]        kind_t;
  typedef logic [15:0]       pos_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam len_t MAX_LEN = LEN_W'(MAX_TOKEN_LENGTH);
  localparam pos_t POS_MAX = 16'hFFFF;

  localparam kind_t KIND_NUMBER   = 3'd0;
  localparam kind_t KIND_QUESTION = 3'd1;
  localparam kind_t KIND_COMMA    = 3'd2;
  localparam kind_t KIND_EOL      = 3'd3;
  localparam kind_t KIND_IDENT    = 3'd4;
  localparam kind_t KIND_LABEL    = 3'd5;
  localparam kind_t KIND_INVALID  = 3'd6;

  localparam logic REG_START_LINE   = 1'b0;
  localparam logic REG_START_COLUMN = 1'b1;

  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_COLON = 8'h3A;
  localparam char_t CH_SEMI  = 8'h3B;
  localparam char_t CH_QUEST = 8'h3F;

  // Write port of the token buffer.
  typedef struct packed {
    logic  en;
    addr_t addr;
    char_t data;
  } att_wr_t;

  // Start of one token read-out.
  typedef struct packed {
    logic  go;
    len_t  len;
    kind_t kind;
    pos_t  line;
    pos_t  col;
    logic  trunc;
  } att_emit_t;

  function automatic logic is_space(input char_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input char_t c);
    return (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

  function automatic logic breaks_ident(input char_t c);
    return (c == CH_COMMA) || (c == CH_COLON) || (c == CH_NL) || (c == CH_SEMI) ||
           is_space(c);
  endfunction

  function automatic kind_t classify(input logic num, input logic ident,
                                     input logic ident_prev, input logic single,
                                     input char_t first, input char_t last);
    kind_t k;
    if (num) k = KIND_NUMBER;
    else if (single && (first == CH_QUEST)) k = KIND_QUESTION;
    else if (single && (first == CH_COMMA)) k = KIND_COMMA;
    else if (single && ((first == CH_NL) || (first == CH_SEMI))) k = KIND_EOL;
    else if (ident) k = KIND_IDENT;
    else if (ident_prev && (last == CH_COLON)) k = KIND_LABEL;
    else k = KIND_INVALID;
    return k;
  endfunction

endpackage

[sv/att_if.sv]
// Valid/ready channel interfaces for source bytes and token characters.
interface att_in_if import att_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t source_byte;
  logic  end_of_source;

  modport source(output valid, source_byte, end_of_source, input ready);
  modport sink(input valid, source_byte, end_of_source, output ready);
endinterface

interface att_out_if import att_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t token_char;
  kind_t token_kind;
  pos_t  line_number;
  pos_t  last_column;
  logic  last_char;
  logic  truncated;

  modport source(output valid, token_char, token_kind, line_number, last_column,
                 last_char, truncated, input ready);
  modport sink(input valid, token_char, token_kind, line_number, last_column,
               last_char, truncated, output ready);
endinterface

[sv/assembly_text_tokenizer.sv]
// Top level of the assembly text tokenizer: lookahead, classification, position and registers.
//
// Source bytes arrive one transfer at a time and the block holds each byte back one transfer,
// so that the following byte acts as its lookahead. Space, tab and carriage return are skipped;
// every other character is written into a 31-entry token buffer memory while the token's type
// (number, question mark, comma, end of line, identifier, label, or invalid) is tracked in a
// few flags. When the lookahead would spoil the type, the token is read back out of the
// buffer memory as a run of character transfers, each carrying the kind, the line and column
// of the token's last character, a final-character mark and a truncation flag. A transfer with
// end_of_source set flushes the held character and any pending token, and reloads the line and
// column counters from start_line and start_column. After a byte that completes no token, the
// next byte can be taken at once. After a byte that completes a token, its stored characters
// are read out one per transfer and the next byte is held off until the last read has been
// issued, because the buffer memory has one read port; the final character may still wait
// in the output register when the next byte is taken. Output stalls lengthen the read-out.
// Characters beyond the buffer's 31 entries are dropped but still count towards the type,
// and every character of such a token is flagged as truncated. The buffer needs no clearing
// after reset, since only written entries are ever read. start_line (reset 1) lies at byte
// address 0 and start_column (reset 0) at byte address 4; a write also loads the matching
// counter at once and should only be made while the block is idle.
module assembly_text_tokenizer import att_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  att_in_if.sink                in_item,
  att_out_if.source             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Configuration registers and position counters.
  pos_t start_line;
  pos_t start_col;
  pos_t line_cnt;
  pos_t col_cnt;

  // Held character and the running state of the token being collected.
  char_t pend_char;
  logic  pend_valid;
  len_t  len;
  logic  ovf;
  logic  num_sf;
  logic  id_sf;
  logic  ib_sf;
  char_t first_char;

  // State as it stands once the held character has been pushed.
  len_t  len_next;
  logic  ovf_next;
  logic  num_next;
  logic  id_next;
  logic  ib_next;
  char_t first_next;
  logic  single_next;

  char_t     c;
  char_t     b;
  logic      end_in;
  logic      in_fire;
  logic      push;
  logic      fresh;
  kind_t     cur;
  kind_t     nxt;
  kind_t     alone;
  logic      emit_now;
  logic      cfg_wr;
  logic      busy;
  att_wr_t   wr;
  att_emit_t start;
  pos_t      line_adv;
  pos_t      col_adv;

  assign c       = pend_char;
  assign b       = in_item.source_byte;
  assign end_in  = in_item.end_of_source;

  // The buffer is being read out while busy, so no byte is taken then; this is the interlock
  // that keeps a new write from landing on an entry still to be read.
  assign in_item.ready = !busy;
  assign in_fire       = in_item.valid && in_item.ready;
  assign push          = in_fire && pend_valid && !is_space(c);
  assign fresh         = (len == '0) && !ovf;

  always_comb begin
    num_next   = num_sf;
    id_next    = id_sf;
    ib_next    = ib_sf;
    len_next   = len;
    ovf_next   = ovf;
    first_next = first_char;
    if (push) begin
      if (fresh) begin
        num_next = is_sign(c) || is_digit(c);
        ib_next  = 1'b1;
        id_next  = !breaks_ident(c);
      end else begin
        ib_next  = id_sf;
        id_next  = id_sf && !breaks_ident(c);
        num_next = num_sf && is_digit(c);
      end
      if (len < MAX_LEN) begin
        len_next = len + len_t'(1);
      end else begin
        ovf_next = 1'b1;
      end
      if (len == '0) begin
        first_next = c;
      end
    end
    single_next = (len_next == len_t'(1)) && !ovf_next;
  end

  // The current type, the type with the lookahead appended, and the lookahead on its own.
  assign cur   = classify(num_next, id_next, ib_next, single_next, first_next, c);
  assign nxt   = classify(num_next && is_digit(b), id_next && !breaks_ident(b), id_next,
                          1'b0, '0, b);
  assign alone = classify(is_sign(b) || is_digit(b), !breaks_ident(b), 1'b1, 1'b1, b, b);

  always_comb begin
    if (end_in) begin
      emit_now = in_fire && (len_next != '0);
    end else begin
      emit_now = push && (nxt == KIND_INVALID) &&
                 ((cur != KIND_INVALID) || (alone != KIND_INVALID));
    end
  end

  assign wr.en   = push && (len < MAX_LEN);
  assign wr.addr = len[ADDR_W-1:0];
  assign wr.data = c;

  assign start.go    = emit_now;
  assign start.len   = len_next;
  assign start.kind  = cur;
  assign start.line  = line_cnt;
  assign start.col   = col_cnt;
  assign start.trunc = ovf_next;

  // Moving past a character: a newline bumps the line and restarts the column, then the
  // column steps on by one. Both counters stop at their maximum.
  always_comb begin
    line_adv = line_cnt;
    col_adv  = col_cnt;
    if (c == CH_NL) begin
      if (line_cnt != POS_MAX) begin
        line_adv = line_cnt + pos_t'(1);
      end
      col_adv = '0;
    end
    if (col_adv != POS_MAX) begin
      col_adv = col_adv + pos_t'(1);
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_START_LINE:   prdata = {16'h0, start_line};
      REG_START_COLUMN: prdata = {16'h0, start_col};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_line <= pos_t'(1);
      start_col  <= '0;
      line_cnt   <= pos_t'(1);
      col_cnt    <= '0;
      pend_char  <= '0;
      pend_valid <= 1'b0;
      len        <= '0;
      ovf        <= 1'b0;
      num_sf     <= 1'b1;
      id_sf      <= 1'b1;
      ib_sf      <= 1'b1;
      first_char <= '0;
    end else begin
      if (in_fire) begin
        if (end_in || emit_now) begin
          len    <= '0;
          ovf    <= 1'b0;
          num_sf <= 1'b1;
          id_sf  <= 1'b1;
          ib_sf  <= 1'b1;
        end else begin
          len    <= len_next;
          ovf    <= ovf_next;
          num_sf <= num_next;
          id_sf  <= id_next;
          ib_sf  <= ib_next;
        end
        first_char <= first_next;
        if (end_in) begin
          pend_valid <= 1'b0;
          pend_char  <= '0;
          line_cnt   <= start_line;
          col_cnt    <= start_col;
        end else begin
          if (pend_valid) begin
            line_cnt <= line_adv;
            col_cnt  <= col_adv;
          end
          pend_char  <= b;
          pend_valid <= 1'b1;
        end
      end
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_START_LINE: begin
            start_line <= pwdata[15:0];
            line_cnt   <= pwdata[15:0];
          end
          REG_START_COLUMN: begin
            start_col <= pwdata[15:0];
            col_cnt   <= pwdata[15:0];
          end
          default: begin
            start_line <= start_line;
          end
        endcase
      end
    end
  end

  att_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .start    (start),
    .busy     (busy),
    .out_item (out_item)
  );

  a_hold_token: assert property (@(posedge clk) disable iff (rst) !pend_valid |-> len == '0)
    else $error("token characters stored with no character held");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst) ovf |-> len == MAX_LEN)
    else $error("truncation flagged before the buffer was full");
  a_busy_empty: assert property (@(posedge clk) disable iff (rst) busy |-> len == '0)
    else $error("token collected while the buffer is being read out");
  a_hold_next: assert property (@(posedge clk) disable iff (rst)
                                in_fire && !end_in |=> pend_valid)
    else $error("source byte taken but not held as the next character");

endmodule

[sv/att_emitter.sv]
// Token buffer memory and the read-out that turns a stored token into a character run.
module att_emitter import att_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  att_wr_t       wr,
  input  att_emit_t     start,
  output logic          busy,
  att_out_if.source     out_item
);

  char_t mem [MAX_TOKEN_LENGTH];

  len_t  idx;
  len_t  e_len;
  kind_t e_kind;
  pos_t  e_line;
  pos_t  e_col;
  logic  e_trunc;

  logic  o_valid;
  char_t o_char;
  kind_t o_kind;
  pos_t  o_line;
  pos_t  o_col;
  logic  o_last;
  logic  o_trunc;

  logic  issue;
  logic  at_end;

  assign issue  = busy && (!o_valid || out_item.ready);
  assign at_end = (idx == (e_len - len_t'(1)));

  // The memory's registered read data is the output register itself.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      o_char <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      o_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (start.go) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (issue) begin
        idx <= idx + len_t'(1);
        if (at_end) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        o_valid <= 1'b1;
      end else if (out_item.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.go) begin
      e_len   <= start.len;
      e_kind  <= start.kind;
      e_line  <= start.line;
      e_col   <= start.col;
      e_trunc <= start.trunc;
    end
    if (issue) begin
      o_kind  <= e_kind;
      o_line  <= e_line;
      o_col   <= e_col;
      o_last  <= at_end;
      o_trunc <= e_trunc;
    end
  end

  assign out_item.valid       = o_valid;
  assign out_item.token_char  = o_char;
  assign out_item.token_kind  = o_kind;
  assign out_item.line_number = o_line;
  assign out_item.last_column = o_col;
  assign out_item.last_char   = o_last;
  assign out_item.truncated   = o_trunc;

  a_go_idle: assert property (@(posedge clk) disable iff (rst) start.go |-> !busy)
    else $error("token read-out started while another is running");
  a_go_len: assert property (@(posedge clk) disable iff (rst) start.go |-> start.len != '0)
    else $error("empty token read-out started");
  a_idx_range: assert property (@(posedge clk) disable iff (rst) busy |-> idx < e_len)
    else $error("read index ran past the token length");
  a_finish: assert property (@(posedge clk) disable iff (rst) issue && at_end |=> !busy)
    else $error("read-out did not finish after its last character");

endmodule
